// ----- hw/rtl/dark_content_bounding_box_core_assert.svh -----
// assertion helpers for the bounding box core
// both expect clk and rst_n in scope
`ifndef DARK_CONTENT_BOUNDING_BOX_CORE_ASSERT_SVH
`define DARK_CONTENT_BOUNDING_BOX_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define DCBB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define DCBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dcbb_pkg.sv -----
package dcbb_pkg;

    // default largest frame dimension
    localparam int MAX_DIM_DEFAULT = 4096;

    // payload widths
    localparam int PIXEL_W    = 8;
    localparam int LEFT_W     = 12;
    localparam int TOP_W      = 12;
    localparam int CWIDTH_W   = 13;
    localparam int CHEIGHT_W  = 13;
    localparam int DIM_REG_W  = 13;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd2;

    // register reset values
    localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd234;
    localparam int DIM_RESET = 1024;

    // crop width granularity
    localparam int ROUND_STEP = 4;

endpackage

// ----- hw/rtl/dcbb_if.sv -----
// pixel stream channel
interface dcbb_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [dcbb_pkg::PIXEL_W-1:0]  grey_pixel;

    modport source (output valid, output grey_pixel, input ready);
    modport sink   (input valid, input grey_pixel, output ready);
endinterface

// crop rectangle channel
interface dcbb_crop_if;
    logic                            valid;
    logic                            ready;
    logic [dcbb_pkg::LEFT_W-1:0]     crop_left;
    logic [dcbb_pkg::TOP_W-1:0]      crop_top;
    logic [dcbb_pkg::CWIDTH_W-1:0]   crop_width;
    logic [dcbb_pkg::CHEIGHT_W-1:0]  crop_height;
    logic                            frame_empty;

    modport source (output valid, output crop_left, output crop_top, output crop_width,
                     output crop_height, output frame_empty, input ready);
    modport sink   (input valid, input crop_left, input crop_top, input crop_width,
                    input crop_height, input frame_empty, output ready);
endinterface

// configuration write channel
interface dcbb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dcbb_pkg::CFG_IDX_W-1:0]   index;
    logic [dcbb_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/dark_content_bounding_box_core.sv -----
// a pixel transfer that closes a frame shows its crop result after passing the input
//   register, the bounding box register and the result register
// throughput: one pixel per cycle; with a result waiting and a second finished frame
//   held behind it, input stalls only when the next frame's last pixel arrives
// reset (rst_n, asynchronous, active low): threshold 234, frame size 1024 x 1024
//   clamped to MAX_DIM, counters and bounding box cleared, all channels empty
module dark_content_bounding_box_core #(
    parameter int MAX_DIM = dcbb_pkg::MAX_DIM_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    dcbb_cfg_if.sink      cfg,
    dcbb_pixel_if.sink    pixel,
    dcbb_crop_if.source   crop
);

    `include "dark_content_bounding_box_core_assert.svh"

    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int WIDE_W  = CNT_W + 2;
    localparam int DIM_RST = (dcbb_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : dcbb_pkg::DIM_RESET;

    // configuration registers (sizes held already clamped)
    logic [dcbb_pkg::PIXEL_W-1:0]  thr_reg;
    logic [DIM_W-1:0]              width_reg;
    logic [DIM_W-1:0]              height_reg;

    // input register
    logic                          s0_valid_reg;
    logic [dcbb_pkg::PIXEL_W-1:0]  s0_pixel_reg;

    // frame scan state
    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  min_reg;
    logic [CNT_W-1:0]  max_reg;
    logic [CNT_W-1:0]  first_reg;
    logic [CNT_W-1:0]  last_reg;
    logic              seen_reg;

    // finished bounding box register
    logic              s1_valid_reg;
    logic              b_seen_reg;
    logic [CNT_W-1:0]  b_min_reg;
    logic [CNT_W-1:0]  b_max_reg;
    logic [CNT_W-1:0]  b_first_reg;
    logic [CNT_W-1:0]  b_last_reg;
    logic [DIM_W-1:0]  b_width_reg;

    // result register
    logic                            crop_valid_reg;
    logic [dcbb_pkg::LEFT_W-1:0]     crop_left_reg;
    logic [dcbb_pkg::TOP_W-1:0]      crop_top_reg;
    logic [dcbb_pkg::CWIDTH_W-1:0]   crop_width_reg;
    logic [dcbb_pkg::CHEIGHT_W-1:0]  crop_height_reg;
    logic                            crop_empty_reg;

    // combinational
    logic              is_dark;
    logic              col_last;
    logic              row_last;
    logic              frame_end;
    logic              out_free;
    logic              s1_free;
    logic              s0_adv;
    logic [CNT_W-1:0]  min_next;
    logic [CNT_W-1:0]  max_next;
    logic [CNT_W-1:0]  first_next;
    logic [CNT_W-1:0]  last_next;
    logic              seen_next;
    logic [WIDE_W-1:0] span_w;
    logic [WIDE_W-1:0] rounded_w;
    logic              past_edge;
    logic [WIDE_W-1:0] fitted_w;

    // size clamp: zero reads as one, oversize as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [dcbb_pkg::DIM_REG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > 32'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= dcbb_pkg::THRESHOLD_RESET;
            width_reg  <= DIM_W'(DIM_RST);
            height_reg <= DIM_W'(DIM_RST);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                dcbb_pkg::REG_DARK_THRESHOLD:
                    thr_reg <= cfg.data[dcbb_pkg::PIXEL_W-1:0];
                dcbb_pkg::REG_IMAGE_WIDTH:
                    width_reg <= clamp_dim(cfg.data[dcbb_pkg::DIM_REG_W-1:0]);
                dcbb_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= clamp_dim(cfg.data[dcbb_pkg::DIM_REG_W-1:0]);
                default:
                    ;
            endcase
        end
    end

    // flow control between stages
    assign out_free    = !crop_valid_reg || crop.ready;
    assign s1_free     = !s1_valid_reg || out_free;
    assign s0_adv      = s0_valid_reg && (!frame_end || s1_free);
    assign pixel.ready = !s0_valid_reg || s0_adv;

    // position within the frame
    assign col_last  = (DIM_W'(col_reg) + DIM_W'(1)) >= width_reg;
    assign row_last  = (DIM_W'(row_reg) + DIM_W'(1)) >= height_reg;
    assign frame_end = col_last && row_last;

    // bounding box update for the pixel in the input register
    assign is_dark = s0_pixel_reg <= thr_reg;

    always_comb
    begin
        min_next   = min_reg;
        max_next   = max_reg;
        first_next = first_reg;
        last_next  = last_reg;
        seen_next  = seen_reg;
        if (is_dark)
        begin
            if (!seen_reg)
            begin
                min_next   = col_reg;
                max_next   = col_reg;
                first_next = row_reg;
                seen_next  = 1'b1;
            end
            else
            begin
                if (col_reg < min_reg)
                    min_next = col_reg;
                if (col_reg > max_reg)
                    max_next = col_reg;
            end
            last_next = row_reg;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (pixel.ready)
            s0_valid_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
            s0_pixel_reg <= pixel.grey_pixel;
    end

    // counters and running bounding box, cleared at the end of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            min_reg   <= CNT_W'(MAX_DIM - 1);
            max_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else if (s0_adv)
        begin
            if (frame_end)
            begin
                col_reg   <= '0;
                row_reg   <= '0;
                min_reg   <= CNT_W'(MAX_DIM - 1);
                max_reg   <= '0;
                first_reg <= '0;
                last_reg  <= '0;
                seen_reg  <= 1'b0;
            end
            else
            begin
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + CNT_W'(1);
                end
                else
                    col_reg <= col_reg + CNT_W'(1);
                min_reg   <= min_next;
                max_reg   <= max_next;
                first_reg <= first_next;
                last_reg  <= last_next;
                seen_reg  <= seen_next;
            end
        end
    end

    // finished bounding box register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= s0_adv && frame_end;
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv && frame_end)
        begin
            b_seen_reg  <= seen_next;
            b_min_reg   <= min_next;
            b_max_reg   <= max_next;
            b_first_reg <= first_next;
            b_last_reg  <= last_next;
            b_width_reg <= width_reg;
        end
    end

    // crop width: round up past the next multiple of four, pull back at the edge
    assign span_w    = WIDE_W'(b_max_reg) - WIDE_W'(b_min_reg) + WIDE_W'(1);
    assign rounded_w = (span_w & ~WIDE_W'(dcbb_pkg::ROUND_STEP - 1))
                       + WIDE_W'(dcbb_pkg::ROUND_STEP);
    assign past_edge = (WIDE_W'(b_min_reg) + rounded_w) > WIDE_W'(b_width_reg);
    assign fitted_w  = past_edge ? rounded_w - WIDE_W'(dcbb_pkg::ROUND_STEP) : rounded_w;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crop_valid_reg <= 1'b0;
        else if (out_free)
            crop_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            if (b_seen_reg)
            begin
                crop_left_reg   <= dcbb_pkg::LEFT_W'(b_min_reg);
                crop_top_reg    <= dcbb_pkg::TOP_W'(b_first_reg);
                crop_width_reg  <= dcbb_pkg::CWIDTH_W'(fitted_w);
                crop_height_reg <= dcbb_pkg::CHEIGHT_W'(b_last_reg)
                                   - dcbb_pkg::CHEIGHT_W'(b_first_reg)
                                   + dcbb_pkg::CHEIGHT_W'(1);
                crop_empty_reg  <= 1'b0;
            end
            else
            begin
                crop_left_reg   <= '0;
                crop_top_reg    <= '0;
                crop_width_reg  <= '0;
                crop_height_reg <= '0;
                crop_empty_reg  <= 1'b1;
            end
        end
    end

    assign crop.valid       = crop_valid_reg;
    assign crop.crop_left   = crop_left_reg;
    assign crop.crop_top    = crop_top_reg;
    assign crop.crop_width  = crop_width_reg;
    assign crop.crop_height = crop_height_reg;
    assign crop.frame_empty = crop_empty_reg;

    // checks
    `DCBB_ASSERT_SAME(a_empty_zero, crop_valid_reg && crop_empty_reg,
        crop_left_reg == '0 && crop_width_reg == '0, "empty frame with nonzero crop")
    `DCBB_ASSERT_SAME(a_width_mult4, crop_valid_reg && !crop_empty_reg,
        crop_width_reg[1:0] == 2'b00, "crop width not a multiple of four")
    `DCBB_ASSERT_SAME(a_min_le_max, seen_reg, min_reg <= max_reg,
        "leftmost dark column right of rightmost")
    `DCBB_ASSERT_NEXT(a_frame_clear, s0_adv && frame_end,
        col_reg == '0 && row_reg == '0 && !seen_reg, "state not cleared after frame")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 2;
    localparam int MAX_SIZE      = dcbb_pkg::MAX_DIM_DEFAULT;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_PIXELS = 500;
    localparam int REPORT_LIMIT  = 40;

    typedef struct packed {
        logic [dcbb_pkg::LEFT_W-1:0]    left;
        logic [dcbb_pkg::TOP_W-1:0]     top;
        logic [dcbb_pkg::CWIDTH_W-1:0]  width;
        logic [dcbb_pkg::CHEIGHT_W-1:0] height;
        logic                           empty;
    } crop_t;

    typedef enum int {STYLE_EMPTY, STYLE_DOT, STYLE_BOX, STYLE_NOISE} frame_style_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dcbb_cfg_if   cfg_if ();
    dcbb_pixel_if pix_if ();
    dcbb_crop_if  crop_if ();

    dark_content_bounding_box_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .pixel (pix_if),
        .crop  (crop_if)
    );

    // register shadow and bounding box state of the predictor
    logic [dcbb_pkg::PIXEL_W-1:0]   thr_reg;
    logic [dcbb_pkg::DIM_REG_W-1:0] width_reg;
    logic [dcbb_pkg::DIM_REG_W-1:0] height_reg;
    logic [dcbb_pkg::LEFT_W-1:0]    col_pos;
    logic [dcbb_pkg::TOP_W-1:0]     row_pos;
    logic [dcbb_pkg::LEFT_W-1:0]    box_left;
    logic [dcbb_pkg::LEFT_W-1:0]    box_right;
    logic [dcbb_pkg::TOP_W-1:0]     box_top;
    logic [dcbb_pkg::TOP_W-1:0]     box_bottom;
    logic                           box_valid;

    crop_t pending_crops[$];
    int    mismatch_count = 0;
    int    crops_checked  = 0;
    int    pixels_sent    = 0;
    bit    gaps_on        = 1'b1;
    bit    crop_hold_req  = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int clamp_size(input logic [dcbb_pkg::DIM_REG_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > MAX_SIZE)
        begin
            return MAX_SIZE;
        end
        return int'(v);
    endfunction

    function void clear_box();
        col_pos    = '0;
        row_pos    = '0;
        box_left   = '1;
        box_right  = '0;
        box_top    = '0;
        box_bottom = '0;
        box_valid  = 1'b0;
    endfunction

    // one pixel through the bounding box tracker, returns 1 when a frame closes
    function automatic bit advance_bounding_box(input logic [dcbb_pkg::PIXEL_W-1:0] pix,
                                                output crop_t res);
        int w;
        int h;
        int cw;
        int ch;
        w   = clamp_size(width_reg);
        h   = clamp_size(height_reg);
        res = '0;
        // widen the box on a dark pixel
        if (pix <= thr_reg)
        begin
            if (!box_valid)
            begin
                box_left  = col_pos;
                box_right = col_pos;
                box_top   = row_pos;
                box_valid = 1'b1;
            end
            else
            begin
                if (col_pos < box_left)
                begin
                    box_left = col_pos;
                end
                if (col_pos > box_right)
                begin
                    box_right = col_pos;
                end
            end
            box_bottom = row_pos;
        end
        // raster position against the current frame size
        if (int'(col_pos) + 1 < w)
        begin
            col_pos = col_pos + 1'b1;
            return 1'b0;
        end
        col_pos = '0;
        if (int'(row_pos) + 1 < h)
        begin
            row_pos = row_pos + 1'b1;
            return 1'b0;
        end
        // frame end: crop rectangle, width rounded up past the next multiple of four
        if (!box_valid)
        begin
            res.empty = 1'b1;
        end
        else
        begin
            cw = int'(box_right) - int'(box_left) + 1;
            ch = int'(box_bottom) - int'(box_top) + 1;
            cw = cw + dcbb_pkg::ROUND_STEP - (cw & (dcbb_pkg::ROUND_STEP - 1));
            if (int'(box_left) + cw > w)
            begin
                cw = cw - dcbb_pkg::ROUND_STEP;
            end
            res.left   = box_left;
            res.top    = box_top;
            res.width  = cw[dcbb_pkg::CWIDTH_W-1:0];
            res.height = ch[dcbb_pkg::CHEIGHT_W-1:0];
        end
        clear_box();
        return 1'b1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [dcbb_pkg::PIXEL_W-1:0] random_pixel();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [dcbb_pkg::PIXEL_W-1:0] dark_value();
        return 8'($urandom_range(0, int'(thr_reg)));
    endfunction

    function automatic logic [dcbb_pkg::PIXEL_W-1:0] bright_value();
        if (thr_reg == '1)
        begin
            return '1;
        end
        return 8'($urandom_range(int'(thr_reg) + 1, 255));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("crop result %0d: %s got %0d want %0d", crops_checked, what, got, want);
        end
    endtask

    // pixel transfer, predicted on acceptance
    task automatic send_pixel(input logic [dcbb_pkg::PIXEL_W-1:0] value, output bit frame_done);
        crop_t res;
        int    gap;
        @(negedge clk);
        pix_if.valid      <= 1'b1;
        pix_if.grey_pixel <= value;
        do @(posedge clk); while (pix_if.ready !== 1'b1);
        pixels_sent++;
        frame_done = advance_bounding_box(value, res);
        if (frame_done)
        begin
            pending_crops.push_back(res);
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            pix_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop offering pixels and wait for every outstanding crop result
    task automatic drain_results();
        @(negedge clk);
        pix_if.valid <= 1'b0;
        while (pending_crops.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dcbb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dcbb_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            dcbb_pkg::REG_DARK_THRESHOLD: thr_reg    = data[dcbb_pkg::PIXEL_W-1:0];
            dcbb_pkg::REG_IMAGE_WIDTH:    width_reg  = data;
            dcbb_pkg::REG_IMAGE_HEIGHT:   height_reg = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // drain, then write the threshold with random upper data bits, which the block must drop, and the frame size
    task automatic set_frame(input logic [dcbb_pkg::PIXEL_W-1:0] thr,
                             input logic [dcbb_pkg::DIM_REG_W-1:0] w,
                             input logic [dcbb_pkg::DIM_REG_W-1:0] h);
        drain_results();
        write_reg(dcbb_pkg::REG_DARK_THRESHOLD, {5'($urandom), thr});
        write_reg(dcbb_pkg::REG_IMAGE_WIDTH, w);
        write_reg(dcbb_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    // whole frame, dark inside the given rectangle and bright outside
    task automatic send_box_frame(input int l, input int r, input int t, input int b);
        int w;
        int h;
        bit done;
        w = clamp_size(width_reg);
        h = clamp_size(height_reg);
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                if (x >= l && x <= r && y >= t && y <= b)
                begin
                    send_pixel(dark_value(), done);
                end
                else
                begin
                    send_pixel(bright_value(), done);
                end
            end
        end
    endtask

    task automatic send_until_frame_end();
        bit done;
        do send_pixel(random_pixel(), done); while (!done);
    endtask

    // threshold left at its reset value, pixels either side of it
    task automatic test_default_threshold();
        logic [dcbb_pkg::PIXEL_W-1:0] pix [8] = '{8'd235, 8'd234, 8'd255, 8'd255,
                                                 8'd255, 8'd255, 8'd0, 8'd255};
        bit done;
        drain_results();
        write_reg(dcbb_pkg::REG_IMAGE_WIDTH, 13'd4);
        write_reg(dcbb_pkg::REG_IMAGE_HEIGHT, 13'd2);
        foreach (pix[i])
        begin
            send_pixel(pix[i], done);
        end
        send_box_frame(1, 0, 0, 0);
    endtask

    task automatic test_threshold_extremes();
        bit done;
        // only zero is dark
        set_frame(8'd0, 13'd4, 13'd2);
        send_box_frame(2, 2, 1, 1);
        // everything is dark
        set_frame(8'd255, 13'd4, 13'd2);
        send_box_frame(0, 3, 0, 1);
        // single pixel frames: dark, empty, then dark again
        set_frame(8'd255, 13'd1, 13'd1);
        send_pixel(8'hFF, done);
        set_frame(8'd0, 13'd1, 13'd1);
        send_pixel(8'hFF, done);
        send_pixel(8'h00, done);
    endtask

    // each remainder of the span width, and pull-back at the right edge
    task automatic test_crop_rounding();
        set_frame(8'd100, 13'd12, 13'd3);
        send_box_frame(3, 3, 1, 1);
        send_box_frame(2, 3, 0, 2);
        send_box_frame(2, 4, 0, 1);
        send_box_frame(4, 7, 2, 2);
        send_box_frame(9, 11, 0, 0);
        send_box_frame(8, 11, 1, 2);
        send_box_frame(0, 11, 0, 2);
        send_box_frame(1, 0, 0, 0);
    endtask

    // frame size shrunk under a running frame
    task automatic test_mid_frame_resize();
        bit done;
        set_frame(8'd128, 13'd8, 13'd4);
        for (int i = 0; i < 6; i++)
        begin
            send_pixel((i == 5) ? 8'd0 : 8'd200, done);
        end
        drain_results();
        write_reg(dcbb_pkg::REG_IMAGE_WIDTH, 13'd4);
        send_until_frame_end();
        set_frame(8'd128, 13'd5, 13'd6);
        repeat (17) send_pixel(random_pixel(), done);
        drain_results();
        write_reg(dcbb_pkg::REG_IMAGE_HEIGHT, 13'd2);
        send_until_frame_end();
    endtask

    // zero and oversized size registers, long frames cut short by a smaller size
    task automatic test_size_limits();
        bit done;
        // zero width and height read as one
        set_frame(8'd50, 13'd0, 13'd0);
        send_pixel(8'd10, done);
        send_pixel(8'd200, done);
        // oversized width clamps, so the row runs on past its low register bits
        set_frame(8'd50, 13'h1005, 13'd1);
        repeat (12) send_pixel(random_pixel(), done);
        drain_results();
        write_reg(dcbb_pkg::REG_IMAGE_WIDTH, 13'd8);
        send_until_frame_end();
        // full-size height, then cut short
        set_frame(8'd50, 13'd1, 13'(MAX_SIZE));
        repeat (10) send_pixel(random_pixel(), done);
        drain_results();
        write_reg(dcbb_pkg::REG_IMAGE_HEIGHT, 13'd4);
        send_until_frame_end();
        // oversized height, then cut short
        set_frame(8'd50, 13'd1, 13'h1FFF);
        repeat (6) send_pixel(random_pixel(), done);
        drain_results();
        write_reg(dcbb_pkg::REG_IMAGE_HEIGHT, 13'd2);
        send_until_frame_end();
    endtask

    // crop side held off while one-pixel frames keep coming
    task automatic test_receiver_hold();
        bit done;
        set_frame(random_pixel(), 13'd1, 13'd1);
        gaps_on       = 1'b0;
        crop_hold_req = 1'b1;
        repeat (40) send_pixel(random_pixel(), done);
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int           start_count;
        int           w;
        int           h;
        int           l;
        int           r;
        int           t;
        int           b;
        int           pick;
        logic [7:0]   thr;
        frame_style_t style;
        bit           done;
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIXELS)
        begin
            gaps_on = ($urandom_range(0, 4) != 0);
            pick    = $urandom_range(0, 99);
            thr     = (pick < 10) ? 8'd0 : (pick < 20) ? 8'd255 : 8'($urandom);
            pick    = $urandom_range(0, 99);
            w       = (pick < 5) ? 0 : (pick < 20) ? $urandom_range(1, 40)
                                                  : $urandom_range(1, 12);
            pick    = $urandom_range(0, 99);
            h       = (pick < 5) ? 0 : (pick < 20) ? $urandom_range(1, 16)
                                                  : $urandom_range(1, 8);
            set_frame(thr, 13'(w), 13'(h));
            w = clamp_size(width_reg);
            h = clamp_size(height_reg);
            // a few frames back to back under one setting
            repeat ($urandom_range(1, 4))
            begin
                style = frame_style_t'($urandom_range(0, 3));
                l     = $urandom_range(0, w - 1);
                r     = $urandom_range(l, w - 1);
                t     = $urandom_range(0, h - 1);
                b     = $urandom_range(t, h - 1);
                case (style)
                    STYLE_EMPTY: send_box_frame(1, 0, 0, 0);
                    STYLE_DOT:   send_box_frame(l, l, t, t);
                    STYLE_BOX:   send_box_frame(l, r, t, b);
                    default:     repeat (w * h) send_pixel(random_pixel(), done);
                endcase
            end
        end
    endtask

    // crop side ready with random stalls, plus one long hold on request
    initial
    begin : crop_sink
        int gap;
        crop_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (crop_hold_req)
            begin
                crop_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                crop_hold_req = 1'b0;
                crop_if.ready <= 1'b1;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    crop_if.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                crop_if.ready <= 1'b1;
            end
        end
    end

    // compare each crop transfer with the oldest prediction
    always @(posedge clk)
    begin : crop_check
        crop_t got;
        crop_t want;
        if (rst_n && crop_if.valid === 1'b1 && crop_if.ready === 1'b1)
        begin
            got.left   = crop_if.crop_left;
            got.top    = crop_if.crop_top;
            got.width  = crop_if.crop_width;
            got.height = crop_if.crop_height;
            got.empty  = crop_if.frame_empty;
            if (pending_crops.size() == 0)
            begin
                report_mismatch("unexpected result, crop_left", int'(got.left), 0);
            end
            else
            begin
                want = pending_crops.pop_front();
                if (got.left !== want.left)
                begin
                    report_mismatch("crop_left", int'(got.left), int'(want.left));
                end
                if (got.top !== want.top)
                begin
                    report_mismatch("crop_top", int'(got.top), int'(want.top));
                end
                if (got.width !== want.width)
                begin
                    report_mismatch("crop_width", int'(got.width), int'(want.width));
                end
                if (got.height !== want.height)
                begin
                    report_mismatch("crop_height", int'(got.height), int'(want.height));
                end
                if (got.empty !== want.empty)
                begin
                    report_mismatch("frame_empty", int'(got.empty), int'(want.empty));
                end
            end
            crops_checked++;
        end
    end

    // give up when no channel has moved for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((pix_if.valid === 1'b1 && pix_if.ready === 1'b1) ||
                (crop_if.valid === 1'b1 && crop_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : main
        pix_if.valid      = 1'b0;
        pix_if.grey_pixel = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = dcbb_pkg::REG_DARK_THRESHOLD;
        cfg_if.data       = '0;
        thr_reg           = dcbb_pkg::THRESHOLD_RESET;
        width_reg         = 13'(dcbb_pkg::DIM_RESET);
        height_reg        = 13'(dcbb_pkg::DIM_RESET);
        clear_box();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_default_threshold();
        test_threshold_extremes();
        test_crop_rounding();
        test_mid_frame_resize();
        test_size_limits();
        test_receiver_hold();
        test_random_frames();

        drain_results();
        if (pending_crops.size() != 0)
        begin
            report_mismatch("results never arrived", 0, pending_crops.size());
        end
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
